@@ rtl/core/s9p_pkg.sv @@
`default_nettype none

package s9p_pkg;

  // Window and field geometry
  localparam int WINDOW    = 28;
  localparam int NUM_SEL   = 9;
  localparam int CNT_W     = 5;
  localparam int SEL_W     = 4;
  localparam int PAYLOAD_W = 28;
  localparam int WORDS_W   = 24;
  localparam int BYTES_W   = 26;

  // Simple-9 layouts, selector 0 first
  localparam int SEL_COUNT [NUM_SEL] = '{28, 14, 9, 7, 5, 4, 3, 2, 1};
  localparam int SEL_BITS  [NUM_SEL] = '{1, 2, 3, 4, 5, 7, 9, 14, 28};

  // Width class of a value that fits no layout
  localparam logic [SEL_W-1:0] CLS_WIDE = 4'd9;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_WIDTH    = 2'd1,
    ERR_CAPACITY = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FULL,
    ST_FLUSH
  } back_state_e;

  // Queue entry: low value bits, width class, end-of-stream mark
  typedef struct packed {
    logic [PAYLOAD_W-1:0] val;
    logic [SEL_W-1:0]     cls;
    logic                 eos;
  } item_t;

  // Window entry
  typedef struct packed {
    logic [PAYLOAD_W-1:0] val;
    logic [SEL_W-1:0]     cls;
  } entry_t;

  // One packed result
  typedef struct packed {
    logic [31:0]        word;
    logic [CNT_W-1:0]   ints;
    err_e               err;
    logic [BYTES_W-1:0] bytes;
    logic               last;
  } result_t;

  // Smallest selector whose field width holds the value, CLS_WIDE if none
  function automatic logic [SEL_W-1:0] classify(input logic [31:0] v);
    logic [SEL_W-1:0] cls;
    cls = CLS_WIDE;
    for (int s = NUM_SEL - 1; s >= 0; s--) begin
      if ((v >> SEL_BITS[s]) == 32'd0) cls = SEL_W'(s);
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/simple9_integer_packer.sv @@
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: value; tlast: end_of_stream
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: packed word, count, bytes;
//                                             tuser: error_code; tlast: run_last
// cfg       in   cfg_valid_i/cfg_ready_o      max_output_words
//
// An item popped from the input queue is written into the window. A full
// window then packs its word; an end-of-stream item flushes the window one
// word at a time (1 to 28 words). The back end's single pack unit pops no
// item while it packs or flushes. Reset is asynchronous and clears control
// state only; window contents are not cleared. The QUEUE_DEPTH-entry queue
// and output register decouple the two sides while the queue has room.
`default_nettype none

module simple9_integer_packer
  import s9p_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,   // [31:0] value
  input  logic               s_axis_tlast,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [63:0]        m_axis_tdata,   // [31:0] packed_word, [36:32] ints_in_word,
                                             // [62:37] total_bytes, [63] zero
  output logic [1:0]         m_axis_tuser,   // [1:0] error_code
  output logic               m_axis_tlast,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [WORDS_W-1:0] cfg_data_i
);

  logic [WORDS_W-1:0] max_words_q;
  logic               item_valid;
  logic               item_pop;
  item_t              item;
  result_t            res;

  // Capacity register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_words_q <= '1;
    end else if (cfg_valid_i) begin
      max_words_q <= cfg_data_i;
    end
  end

  s9p_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_value_i    (s_axis_tdata),
    .s_eos_i      (s_axis_tlast),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  s9p_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_words_i  (max_words_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  // Result packing onto the master side
  assign m_axis_tdata = {1'b0, res.bytes, res.ints, res.word};
  assign m_axis_tuser = 2'(res.err);
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

@@ rtl/core/s9p_front.sv @@
`default_nettype none

module s9p_front
  import s9p_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  output logic        s_ready_o,
  input  logic [31:0] s_value_i,
  input  logic        s_eos_i,
  output logic        item_valid_o,
  output item_t       item_o,
  input  logic        item_pop_i
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  item_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              push;

  assign s_ready_o    = (fill_q != FILL_W'(QUEUE_DEPTH));
  assign push         = s_valid_i && s_ready_o;
  assign item_valid_o = (fill_q != '0);
  assign item_o       = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (item_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({push, item_pop_i})
      2'b10:   fill_d = fill_q + FILL_W'(1);
      2'b01:   fill_d = fill_q - FILL_W'(1);
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Classify on entry; only the low 28 bits are ever packed
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{val: s_value_i[PAYLOAD_W-1:0],
                           cls: classify(s_value_i),
                           eos: s_eos_i};
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/s9p_back.sv @@
`default_nettype none

module s9p_back
  import s9p_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [WORDS_W-1:0] max_words_i,
  input  logic               item_valid_i,
  input  item_t              item_i,
  output logic               item_pop_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output result_t            res_o
);

  back_state_e         state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [WORDS_W-1:0]  words_q, words_d;
  logic                latched_q, latched_d;
  logic                out_valid_q, out_valid_d;
  result_t             res_q, res_d;
  entry_t              win_q [WINDOW];

  logic                out_free;
  logic                emit;
  logic                do_append;
  logic                do_shift;
  err_e                err;
  logic [NUM_SEL-1:0]  fit;
  logic [SEL_W-1:0]    sel;
  logic [CNT_W-1:0]    n_take;
  logic [CNT_W-1:0]    count_left;
  logic [WORDS_W-1:0]  words_inc;
  logic [NUM_SEL-1:0][PAYLOAD_W-1:0] word_s;
  entry_t              shift_src [WINDOW][NUM_SEL];

  assign out_free   = !out_valid_q || res_ready_i;
  assign words_inc  = words_q + WORDS_W'(1);
  assign res_valid_o = out_valid_q;
  assign res_o      = res_q;

  // Capacity first, then head width
  always_comb begin
    if (words_q >= max_words_i)       err = ERR_CAPACITY;
    else if (win_q[0].cls == CLS_WIDE) err = ERR_WIDTH;
    else                               err = ERR_NONE;
  end

  // Per-layout fit check and packed payload
  for (genvar s = 0; s < NUM_SEL; s++) begin : g_sel
    localparam int N = SEL_COUNT[s];
    localparam int B = SEL_BITS[s];
    logic [N-1:0] ok_bits;
    for (genvar i = 0; i < N; i++) begin : g_ent
      assign ok_bits[i] = (win_q[i].cls <= SEL_W'(s));
      assign word_s[s][i*B +: B] = win_q[i].val[B-1:0];
    end
    if (N * B < PAYLOAD_W) begin : g_pad
      assign word_s[s][PAYLOAD_W-1:N*B] = '0;
    end
    assign fit[s] = (count_q >= CNT_W'(N)) && (&ok_bits);
  end

  // Densest layout that fits
  always_comb begin
    sel = SEL_W'(NUM_SEL - 1);
    for (int s = NUM_SEL - 1; s >= 0; s--) begin
      if (fit[s]) sel = SEL_W'(s);
    end
  end

  assign n_take     = CNT_W'(SEL_COUNT[sel]);
  assign count_left = count_q - n_take;

  // Shift sources for each window slot and layout
  for (genvar j = 0; j < WINDOW; j++) begin : g_shift
    for (genvar s = 0; s < NUM_SEL; s++) begin : g_src
      if (j + SEL_COUNT[s] < WINDOW) begin : g_in
        assign shift_src[j][s] = win_q[j + SEL_COUNT[s]];
      end else begin : g_out
        assign shift_src[j][s] = win_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (do_append && (count_q == CNT_W'(j))) begin
        win_q[j] <= '{val: item_i.val, cls: item_i.cls};
      end else if (do_shift) begin
        win_q[j] <= shift_src[j][sel];
      end
    end
  end

  // FSM outputs
  always_comb begin
    item_pop_o = (state_q == ST_IDLE) && item_valid_i;
    emit       = (state_q != ST_IDLE) && out_free;
  end

  // FSM next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_pop_o && !latched_q) begin
          if (item_i.eos)                          state_d = ST_FLUSH;
          else if (count_q == CNT_W'(WINDOW - 1))  state_d = ST_FULL;
        end
      end
      ST_FULL: begin
        if (emit) state_d = ST_IDLE;
      end
      ST_FLUSH: begin
        if (emit && (err != ERR_NONE || count_left == '0)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Stream state and result datapath
  always_comb begin
    count_d   = count_q;
    words_d   = words_q;
    latched_d = latched_q;
    do_append = 1'b0;
    do_shift  = 1'b0;
    res_d     = '{word: '0, ints: '0, err: err, bytes: {words_q, 2'b00}, last: 1'b0};

    if (item_pop_o) begin
      if (latched_q) begin
        // dropped; end of stream closes the failed stream
        if (item_i.eos) begin
          latched_d = 1'b0;
          words_d   = '0;
        end
      end else begin
        do_append = 1'b1;
        count_d   = count_q + CNT_W'(1);
      end
    end

    if (emit) begin
      if (err != ERR_NONE) begin
        res_d.last = 1'b1;
        count_d    = '0;
        if (state_q == ST_FULL) begin
          latched_d = 1'b1;
        end else begin
          words_d   = '0;
          latched_d = 1'b0;
        end
      end else begin
        do_shift    = 1'b1;
        res_d.word  = {word_s[sel], sel};
        res_d.ints  = n_take;
        res_d.bytes = {words_inc, 2'b00};
        res_d.last  = (state_q == ST_FULL) || (count_left == '0);
        count_d     = count_left;
        words_d     = (state_q == ST_FLUSH && count_left == '0) ? '0 : words_inc;
      end
    end

    out_valid_d = emit || (out_valid_q && !res_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      words_q     <= '0;
      latched_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      words_q     <= words_d;
      latched_q   <= latched_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (emit) res_q <= res_d;
  end

endmodule

`default_nettype wire

@@ rtl/core/s9p_checker.sv @@
`default_nettype none

module s9p_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled result transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // An error result carries no word and ends its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != 2'd0 |->
      m_axis_tdata[36:0] == 37'd0 && m_axis_tlast)
    else $error("error result not empty or not last");

  // A good word holds at least one integer and a valid selector
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == 2'd0 |->
      m_axis_tdata[36:32] != 5'd0 && m_axis_tdata[3:0] <= 4'd8)
    else $error("bad good-word fields");

  // Byte count is whole words and the error code is known
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[38:37] == 2'd0 && m_axis_tuser != 2'd3)
    else $error("bad byte count or error code");

endmodule

bind simple9_integer_packer s9p_checker u_checker (.*);

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import s9p_pkg::*;

  localparam int DRAIN_CYCLES   = 40;    // queue + window + 28-word flush + output reg, padded
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_DIR_ROWS   = 24;
  localparam int NUM_PHASES     = 5;
  localparam int PHASE_ITEMS    = 6;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  // One line of the directed table; value doubles as the capacity on ROW_CFG
  typedef struct {
    row_kind_e   kind;
    logic [31:0] value;
    bit          eos;
    int          reps;
    bit          typed;
    result_t     want;
  } row_t;

  localparam result_t NO_WORD = '0;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata;   // [31:0] value
  logic               s_axis_tlast;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [63:0]        m_axis_tdata;   // [31:0] packed_word, [36:32] ints_in_word,
                                      // [62:37] total_bytes, [63] zero
  logic [1:0]         m_axis_tuser;   // [1:0] error_code
  logic               m_axis_tlast;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [WORDS_W-1:0] cfg_data_i;

  simple9_integer_packer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Directed table: extremes, layouts, width/capacity errors, restart after error
  row_t dir_rows [NUM_DIR_ROWS] = '{
    '{ROW_ITEM, 32'h0000_0005, 1'b1, 1,  1'b1, '{32'h0000_0058, 5'd1, ERR_NONE, 26'd4, 1'b1}},
    '{ROW_ITEM, 32'h0FFF_FFFF, 1'b1, 1,  1'b1, '{32'hFFFF_FFF8, 5'd1, ERR_NONE, 26'd4, 1'b1}},
    '{ROW_ITEM, 32'h1000_0000, 1'b1, 1,  1'b1, '{32'h0, 5'd0, ERR_WIDTH, 26'd0, 1'b1}},
    '{ROW_ITEM, 32'hFFFF_FFFF, 1'b1, 1,  1'b1, '{32'h0, 5'd0, ERR_WIDTH, 26'd0, 1'b1}},
    '{ROW_ITEM, 32'h0000_0000, 1'b1, 1,  1'b1, '{32'h0000_0008, 5'd1, ERR_NONE, 26'd4, 1'b1}},
    '{ROW_ITEM, 32'h0000_0001, 1'b1, 28, 1'b1, '{32'hFFFF_FFF0, 5'd28, ERR_NONE, 26'd4, 1'b1}},
    '{ROW_ITEM, 32'h0000_0003, 1'b0, 1,  1'b0, NO_WORD},
    '{ROW_ITEM, 32'h0000_0002, 1'b1, 1,  1'b0, NO_WORD},
    '{ROW_ITEM, 32'h0000_001F, 1'b0, 1,  1'b0, NO_WORD},
    '{ROW_ITEM, 32'h0000_0000, 1'b0, 1,  1'b0, NO_WORD},
    '{ROW_ITEM, 32'h0000_01FF, 1'b0, 1,  1'b0, NO_WORD},
    '{ROW_ITEM, 32'h0000_3FFF, 1'b1, 1,  1'b0, NO_WORD},
    '{ROW_ITEM, 32'h1000_0000, 1'b0, 1,  1'b0, NO_WORD},
    '{ROW_ITEM, 32'h0000_0004, 1'b1, 1,  1'b1, '{32'h0, 5'd0, ERR_WIDTH, 26'd0, 1'b1}},
    '{ROW_ITEM, 32'h0000_0006, 1'b0, 1,  1'b0, NO_WORD},
    '{ROW_ITEM, 32'h1000_0000, 1'b0, 1,  1'b0, NO_WORD},
    '{ROW_ITEM, 32'h0000_0009, 1'b1, 1,  1'b0, NO_WORD},
    '{ROW_CFG,  32'h0000_0000, 1'b0, 1,  1'b0, NO_WORD},
    '{ROW_ITEM, 32'h0000_0007, 1'b1, 1,  1'b1, '{32'h0, 5'd0, ERR_CAPACITY, 26'd0, 1'b1}},
    '{ROW_ITEM, 32'hFFFF_FFFF, 1'b1, 1,  1'b1, '{32'h0, 5'd0, ERR_CAPACITY, 26'd0, 1'b1}},
    '{ROW_CFG,  32'h0000_0001, 1'b0, 1,  1'b0, NO_WORD},
    '{ROW_ITEM, 32'h0FFF_FFFF, 1'b0, 1,  1'b0, NO_WORD},
    '{ROW_ITEM, 32'h00AB_CDEF, 1'b1, 1,  1'b0, NO_WORD},
    '{ROW_CFG,  32'h00FF_FFFF, 1'b0, 1,  1'b0, NO_WORD}
  };

  // Packer state as seen from outside
  logic [31:0]        win [WINDOW];
  int unsigned        win_cnt;
  logic [WORDS_W-1:0] words_out;
  logic [WORDS_W-1:0] cap_words;
  bit                 stream_err;

  result_t words_due [$];
  int      failures;
  int      quiet_cycles;
  bit      send_calm;
  bit      recv_calm;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Gap before the next transaction, with occasional stretches of none
  function automatic int draw_gap(ref bit calm);
    if ($urandom_range(0, 15) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic void restart_stream();
    win_cnt    = 0;
    words_out  = '0;
    stream_err = 1'b0;
  endfunction

  // Pack one word from the window head: capacity first, then head width
  function automatic result_t pack_head_word();
    result_t     r;
    int          sel;
    int          n;
    bit          fits;
    logic [31:0] acc;
    r   = '0;
    sel = NUM_SEL - 1;
    acc = '0;
    if (words_out >= cap_words) begin
      r.err = ERR_CAPACITY;
    end else if (win[0][31:28] != 4'd0) begin
      r.err = ERR_WIDTH;
    end else begin
      // densest layout whose leading entries all fit
      for (int s = NUM_SEL - 1; s >= 0; s--) begin
        fits = SEL_COUNT[s] <= win_cnt;
        for (int i = 0; i < SEL_COUNT[s]; i++) begin
          if (fits && (win[i] >> SEL_BITS[s]) != 32'd0) fits = 1'b0;
        end
        if (fits) sel = s;
      end
      n = SEL_COUNT[sel];
      for (int i = 0; i < n; i++) acc |= win[i] << (i * SEL_BITS[sel]);
      r.word = {acc[PAYLOAD_W-1:0], SEL_W'(sel)};
      r.ints = CNT_W'(n);
      for (int i = 0; i < WINDOW - n; i++) win[i] = win[i + n];
      win_cnt   -= n;
      words_out += 1'b1;
    end
    r.bytes = {words_out, 2'b00};
    return r;
  endfunction

  // Words one accepted integer causes
  function automatic void predict_packing(input logic [31:0] v, input bit eos,
                                          ref result_t batch[$]);
    result_t r;
    batch = {};
    if (stream_err) begin
      // dropped until end of stream
      if (eos) restart_stream();
      return;
    end
    if (win_cnt < WINDOW) begin
      win[win_cnt] = v;
      win_cnt++;
    end
    if (eos) begin
      while (win_cnt > 0 && batch.size() < WINDOW) begin
        r = pack_head_word();
        batch.insert(batch.size(), r);
        if (r.err != ERR_NONE) break;
      end
      restart_stream();
    end else if (win_cnt >= WINDOW) begin
      r = pack_head_word();
      if (r.err != ERR_NONE) begin
        stream_err = 1'b1;
        win_cnt    = 0;
      end
      batch.insert(batch.size(), r);
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
  endfunction

  // Send one integer; typed rows replace the predicted word with the table's
  task automatic push_value(input logic [31:0] v, input bit eos, input bit typed,
                            input result_t typed_word);
    int      gap;
    result_t batch [$];
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_packing(v, eos, batch);
    if (typed) words_due.insert(words_due.size(), typed_word);
    else foreach (batch[i]) words_due.insert(words_due.size(), batch[i]);
  endtask

  // Wait out every expected word plus the block's own latency
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [WORDS_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cap_words = v;
  endtask

  // One random stream: mostly well-formed, some wide noise, some broken mid-stream
  task automatic send_stream(output int len);
    int          kind;
    int          wmax;
    int          wide_at;
    int          w;
    logic [31:0] v;
    kind    = $urandom_range(0, 9);
    wide_at = -1;
    if (kind <= 5) begin
      len  = $urandom_range(1, 12);
      wmax = $urandom_range(0, 28);
    end else if (kind <= 7) begin
      len  = $urandom_range(29, 70);
      wmax = $urandom_range(0, 9);
    end else if (kind == 8) begin
      len  = $urandom_range(1, 10);
      wmax = 32;
    end else begin
      len     = $urandom_range(30, 50);
      wmax    = $urandom_range(0, 14);
      wide_at = $urandom_range(0, len - 1);
    end
    for (int i = 0; i < len; i++) begin
      w = $urandom_range(0, wmax);
      v = $urandom & 32'((64'd1 << w) - 1);
      if (i == wide_at) begin
        v = $urandom;
        if (v[31:28] == 4'd0) v[28] = 1'b1;
      end
      push_value(v, i == len - 1, 1'b0, NO_WORD);
    end
  endtask

  // Compare one field of a packed word
  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
      failures++;
    end
  endfunction

  task automatic check_word();
    result_t got;
    result_t want;
    got.word  = m_axis_tdata[31:0];
    got.ints  = m_axis_tdata[36:32];
    got.bytes = m_axis_tdata[62:37];
    got.err   = err_e'(m_axis_tuser);
    got.last  = m_axis_tlast;
    if (words_due.size() == 0) begin
      $display("%0t: unexpected word: expected none actual %h", $time, got.word);
      failures++;
    end else begin
      want = words_due.pop_front();
      compare_field("packed_word", want.word, got.word);
      compare_field("ints_in_word", 32'(want.ints), 32'(got.ints));
      compare_field("error_code", 32'(want.err), 32'(got.err));
      compare_field("total_bytes", 32'(want.bytes), 32'(got.bytes));
      compare_field("run_last", 32'(want.last), 32'(got.last));
    end
  endtask

  // Output side: random backpressure, check each accepted word
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_gap(recv_calm);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      check_word();
    end
  end

  // Watchdog: cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    logic [WORDS_W-1:0] caps [NUM_PHASES];
    int                 phase_items;
    int                 len;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    send_calm     = 1'b0;
    cap_words     = 24'hFF_FFFF;
    restart_stream();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        settle();
        write_capacity(dir_rows[r].value[WORDS_W-1:0]);
      end else begin
        for (int k = 0; k < dir_rows[r].reps; k++) begin
          push_value(dir_rows[r].value, dir_rows[r].eos && k == dir_rows[r].reps - 1,
                     dir_rows[r].typed && k == dir_rows[r].reps - 1, dir_rows[r].want);
        end
      end
    end

    // random phases, each under its own capacity
    caps = '{24'hFF_FFFF, 24'd0, 24'd1, WORDS_W'($urandom_range(2, 12)), 24'hFF_FFFF};
    foreach (caps[p]) begin
      settle();
      write_capacity(caps[p]);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        send_stream(len);
        phase_items += len;
      end
    end

    settle();
    if (failures == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
